// ===== hdl/prsdet_pkg.sv =====
// ----------------------------------------------------------------------------
// prsdet_pkg
// Shared types and constants for the press detector: sequencer states,
// controller commands and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package prsdet_pkg;

   // number of valid key indexes; a key at or above this counts as absent
   localparam int KEY_COUNT = 256;

   // retreat beyond the closest point that cancels a latched approach (3 mm)
   localparam logic signed [16:0] RETREAT_TOL = 17'sd48;

   // velocity scaling: ms per second
   localparam logic signed [26:0] MS_PER_S = 27'sd1000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOUCH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DWELL_TIME = 3'd4;

   localparam logic [15:0] TIMEOUT_RST    = 16'd200;
   localparam logic [15:0] RELEASE_RST    = 16'd320;
   localparam logic [15:0] TOUCH_RST      = 16'd0;
   localparam logic [15:0] MIN_SPEED_RST  = 16'd100;
   localparam logic [15:0] DWELL_TIME_RST = 16'd0;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_LOST   = 1'b1;

   localparam logic TRIG_APPROACH = 1'b0;
   localparam logic TRIG_DWELL    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_UPDATE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic compute;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/press_detect_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// press_detect_fsm_unit
// Key-press detector for a fingertip over a virtual key plane.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     kind, stamp, distance, key
//   rsp      out        rsp_valid / rsp_stall     press, flags, dwell time
//   csr      in         csr_wr_en                 csr_index, csr_wdata
//
// One word passes through four steps: capture, multiply, state update, result.
// The multiply step (speed times time gap) has a state of its own in the sequence.
// A stalled result holds and no new word is taken until it leaves.
// Reset is synchronous and restores the register defaults and clears state.
// ----------------------------------------------------------------------------
`default_nettype none

module press_detect_fsm_unit
   import prsdet_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_kind,
   input  wire  [31:0]             req_stamp,
   input  wire  signed [15:0]      req_distance,
   input  wire                     req_key_present,
   input  wire  [7:0]              req_key_index,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_fire,
   output logic                    rsp_trigger,
   output logic [7:0]              rsp_press_key,
   output logic [31:0]             rsp_press_stamp,
   output logic                    rsp_is_armed,
   output logic                    rsp_is_latched,
   output logic                    rsp_dwell_active,
   output logic [31:0]             rsp_dwell_elapsed,
   input  wire                     csr_wr_en,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata
);

   cmd_type cmd;

   prsdet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   prsdet_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_stamp         (req_stamp),
      .req_distance      (req_distance),
      .req_key_present   (req_key_present),
      .req_key_index     (req_key_index),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_fire          (rsp_fire),
      .rsp_trigger       (rsp_trigger),
      .rsp_press_key     (rsp_press_key),
      .rsp_press_stamp   (rsp_press_stamp),
      .rsp_is_armed      (rsp_is_armed),
      .rsp_is_latched    (rsp_is_latched),
      .rsp_dwell_active  (rsp_dwell_active),
      .rsp_dwell_elapsed (rsp_dwell_elapsed)
   );

`ifndef NO_ASSERTIONS
   a_accept_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result shown right after a word was taken");

   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fire |-> !rsp_is_armed && !rsp_is_latched && !rsp_dwell_active)
      else $error("press left the detector armed, latched or dwelling");

   a_idle_press_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fire |->
         rsp_press_stamp == 32'd0 && rsp_press_key == 8'd0 && !rsp_trigger)
      else $error("press fields set without a press");

   a_dwell_elapsed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dwell_active |-> rsp_dwell_elapsed == 32'd0)
      else $error("dwell time reported without an active dwell");
`endif

endmodule

`default_nettype wire

// ===== hdl/prsdet_ctrl.sv =====
// ----------------------------------------------------------------------------
// prsdet_ctrl
// Sequencer: capture a word, run the multiply step, commit the state update,
// then hold the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module prsdet_ctrl
   import prsdet_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MULT;
         end
         ST_MULT:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SEND;
         ST_SEND: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_MULT:   cmd.compute = 1'b1;
         ST_UPDATE: cmd.commit  = 1'b1;
         ST_SEND:   rsp_valid   = 1'b1;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/prsdet_dp.sv =====
// ----------------------------------------------------------------------------
// prsdet_dp
// Datapath: configuration registers, tracking state, velocity products and
// the press decision with its result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prsdet_dp
   import prsdet_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  cmd_type                 cmd,
   input  wire                     req_kind,
   input  wire  [31:0]             req_stamp,
   input  wire  signed [15:0]      req_distance,
   input  wire                     req_key_present,
   input  wire  [7:0]              req_key_index,
   input  wire                     csr_wr_en,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata,
   output logic                    rsp_fire,
   output logic                    rsp_trigger,
   output logic [7:0]              rsp_press_key,
   output logic [31:0]             rsp_press_stamp,
   output logic                    rsp_is_armed,
   output logic                    rsp_is_latched,
   output logic                    rsp_dwell_active,
   output logic [31:0]             rsp_dwell_elapsed
);

   // configuration
   logic [15:0]        timeout_ff;
   logic signed [15:0] release_ff;
   logic signed [15:0] touch_ff;
   logic [15:0]        min_speed_ff;
   logic [15:0]        dwell_time_ff;

   // tracking state
   logic               armed_ff,         armed_in;
   logic               latch_ff,         latch_in;
   logic               closest_valid_ff, closest_valid_in;
   logic signed [15:0] closest_ff,       closest_in;
   logic               prior_valid_ff,   prior_valid_in;
   logic signed [15:0] prior_ff,         prior_in;
   logic               seen_valid_ff,    seen_valid_in;
   logic [31:0]        seen_stamp_ff,    seen_stamp_in;
   logic               dwell_valid_ff,   dwell_valid_in;
   logic [31:0]        dwell_start_ff,   dwell_start_in;
   logic [7:0]         dwell_key_ff,     dwell_key_in;

   // captured word
   logic               kind_ff;
   logic [31:0]        stamp_ff;
   logic signed [15:0] dist_ff;
   logic               keyp_ff;
   logic [7:0]         key_ff;

   // multiply step
   logic [31:0]        seen_diff;
   logic signed [16:0] vel_diff;
   logic               timed_out_ff,  timed_out_in;
   logic               dt_pos_ff,     dt_pos_in;
   logic signed [26:0] lhs_ff,        lhs_in;
   logic [46:0]        rhs_ff,        rhs_in;
   logic [31:0]        elapsed_ff,    elapsed_in;

   // result
   logic               fire_in, trig_in;
   logic [7:0]         pkey_in;
   logic [31:0]        pstamp_in, delapsed_in;

   logic               speed_ok, has_key, in_zone, dwell_ok, restart;
   logic [31:0]        dwell_el;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         stamp_ff <= req_stamp;
         dist_ff  <= req_distance;
         keyp_ff  <= req_key_present;
         key_ff   <= req_key_index;
      end
   end

   // time gaps and velocity products
   always_comb begin
      seen_diff    = stamp_ff - seen_stamp_ff;
      timed_out_in = seen_valid_ff && ($signed(seen_diff) > $signed({16'd0, timeout_ff}));
      dt_pos_in    = !seen_diff[31] && (seen_diff != 32'd0);
      vel_diff     = 17'(prior_ff) - 17'(dist_ff);
      lhs_in       = 27'(vel_diff) * MS_PER_S;
      rhs_in       = 47'(min_speed_ff) * 47'(seen_diff[30:0]);
      elapsed_in   = stamp_ff - dwell_start_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         timed_out_ff <= timed_out_in;
         dt_pos_ff    <= dt_pos_in;
         lhs_ff       <= lhs_in;
         rhs_ff       <= rhs_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   // state update and press decision
   always_comb begin
      armed_in         = armed_ff;
      latch_in         = latch_ff;
      closest_valid_in = closest_valid_ff;
      closest_in       = closest_ff;
      prior_valid_in   = prior_valid_ff;
      prior_in         = prior_ff;
      seen_valid_in    = seen_valid_ff;
      seen_stamp_in    = seen_stamp_ff;
      dwell_valid_in   = dwell_valid_ff;
      dwell_start_in   = dwell_start_ff;
      dwell_key_in     = dwell_key_ff;
      fire_in          = 1'b0;
      trig_in          = TRIG_APPROACH;
      pkey_in          = 8'd0;
      pstamp_in        = 32'd0;
      speed_ok         = (min_speed_ff == 16'd0);
      has_key          = keyp_ff && (int'(key_ff) < KEY_COUNT);
      in_zone          = 1'b0;
      dwell_ok         = 1'b0;
      restart          = 1'b0;

      if (timed_out_ff) begin
         armed_in         = 1'b0;
         prior_valid_in   = 1'b0;
         prior_in         = '0;
         latch_in         = 1'b0;
         closest_valid_in = 1'b0;
         closest_in       = '0;
         dwell_valid_in   = 1'b0;
         dwell_start_in   = '0;
         dwell_key_in     = '0;
      end

      if (kind_ff == KIND_LOST) begin
         prior_valid_in   = 1'b0;
         prior_in         = '0;
         latch_in         = 1'b0;
         closest_valid_in = 1'b0;
         closest_in       = '0;
         dwell_valid_in   = 1'b0;
         dwell_start_in   = '0;
         dwell_key_in     = '0;
      end else begin
         if (dist_ff >= release_ff) begin
            armed_in         = 1'b1;
            latch_in         = 1'b0;
            closest_valid_in = 1'b0;
            closest_in       = '0;
            dwell_valid_in   = 1'b0;
            dwell_start_in   = '0;
            dwell_key_in     = '0;
         end
         // a timed-out prior still feeds the approach test, at zero speed
         if (prior_valid_in && seen_valid_ff && dt_pos_ff) begin
            speed_ok = $signed({{25{lhs_ff[26]}}, lhs_ff}) >= $signed({1'b0, rhs_ff, 4'd0});
         end
         if (prior_valid_ff && (dist_ff < prior_ff) && speed_ok) latch_in = 1'b1;
         if (latch_in) begin
            if (!closest_valid_in || (dist_ff < closest_in)) begin
               closest_valid_in = 1'b1;
               closest_in       = dist_ff;
            end else if (17'(dist_ff) > 17'(closest_in) + RETREAT_TOL) begin
               latch_in         = 1'b0;
               closest_valid_in = 1'b0;
               closest_in       = '0;
            end
         end
         prior_valid_in = 1'b1;
         prior_in       = dist_ff;
         seen_valid_in  = 1'b1;
         seen_stamp_in  = stamp_ff;

         in_zone = (dist_ff <= touch_ff) && has_key;
         if (in_zone) begin
            if (!dwell_valid_in || (dwell_key_in != key_ff)) begin
               restart        = 1'b1;
               dwell_valid_in = 1'b1;
               dwell_start_in = stamp_ff;
               dwell_key_in   = key_ff;
            end
         end else begin
            dwell_valid_in = 1'b0;
            dwell_start_in = '0;
            dwell_key_in   = '0;
         end
      end

      // a fresh dwell start has zero elapsed time
      dwell_el = restart ? 32'd0 : elapsed_ff;
      dwell_ok = (dwell_time_ff != 16'd0) && dwell_valid_in
                 && ($signed(dwell_el) >= $signed({16'd0, dwell_time_ff}));

      if (kind_ff == KIND_SAMPLE) begin
         if (armed_in && in_zone && (latch_in || dwell_ok)) begin
            fire_in          = 1'b1;
            trig_in          = latch_in ? TRIG_APPROACH : TRIG_DWELL;
            pkey_in          = key_ff;
            pstamp_in        = stamp_ff;
            armed_in         = 1'b0;
            latch_in         = 1'b0;
            closest_valid_in = 1'b0;
            closest_in       = '0;
            dwell_valid_in   = 1'b0;
            dwell_start_in   = '0;
            dwell_key_in     = '0;
         end else if (dist_ff <= touch_ff) begin
            latch_in         = 1'b0;
            closest_valid_in = 1'b0;
            closest_in       = '0;
         end
      end

      delapsed_in = (dwell_valid_in && !dwell_el[31]) ? dwell_el : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_fire          <= fire_in;
         rsp_trigger       <= trig_in;
         rsp_press_key     <= pkey_in;
         rsp_press_stamp   <= pstamp_in;
         rsp_is_armed      <= armed_in;
         rsp_is_latched    <= latch_in;
         rsp_dwell_active  <= dwell_valid_in;
         rsp_dwell_elapsed <= delapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff       <= TIMEOUT_RST;
         release_ff       <= RELEASE_RST;
         touch_ff         <= TOUCH_RST;
         min_speed_ff     <= MIN_SPEED_RST;
         dwell_time_ff    <= DWELL_TIME_RST;
         armed_ff         <= 1'b0;
         latch_ff         <= 1'b0;
         closest_valid_ff <= 1'b0;
         closest_ff       <= '0;
         prior_valid_ff   <= 1'b0;
         prior_ff         <= '0;
         seen_valid_ff    <= 1'b0;
         seen_stamp_ff    <= '0;
         dwell_valid_ff   <= 1'b0;
         dwell_start_ff   <= '0;
         dwell_key_ff     <= '0;
      end else begin
         if (cmd.commit) begin
            armed_ff         <= armed_in;
            latch_ff         <= latch_in;
            closest_valid_ff <= closest_valid_in;
            closest_ff       <= closest_in;
            prior_valid_ff   <= prior_valid_in;
            prior_ff         <= prior_in;
            seen_valid_ff    <= seen_valid_in;
            seen_stamp_ff    <= seen_stamp_in;
            dwell_valid_ff   <= dwell_valid_in;
            dwell_start_ff   <= dwell_start_in;
            dwell_key_ff     <= dwell_key_in;
         end
         if (csr_wr_en && (csr_index <= CSR_DWELL_TIME)) begin
            case (csr_index)
               CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
               CSR_RELEASE:    release_ff    <= csr_wdata;
               CSR_TOUCH:      touch_ff      <= csr_wdata;
               CSR_MIN_SPEED:  min_speed_ff  <= csr_wdata;
               CSR_DWELL_TIME: dwell_time_ff <= csr_wdata;
               default:        timeout_ff    <= timeout_ff;
            endcase
            // any register write drops the latch and the dwell
            latch_ff         <= 1'b0;
            closest_valid_ff <= 1'b0;
            closest_ff       <= '0;
            dwell_valid_ff   <= 1'b0;
            dwell_start_ff   <= '0;
            dwell_key_ff     <= '0;
         end
      end
   end

endmodule

`default_nettype wire
